### rtl/assert_macros.svh
// Assertion macros for the RTL files; the classifier core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cilc_pkg.sv
// Types and constants shared by the integer literal classifier.
package cilc_pkg;

	localparam int VALUE_BITS = 32;
	localparam int CMP_W      = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIGNED_INT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNSIGNED_INT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIGNED_LONG  = 2'd2;

	localparam logic [CFG_W-1:0] RST_MAX_SIGNED_INT   = 32'd32767;
	localparam logic [CFG_W-1:0] RST_MAX_UNSIGNED_INT = 32'd65535;
	localparam logic [CFG_W-1:0] RST_MAX_SIGNED_LONG  = 32'd2147483647;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} cilc_radix_t;

	typedef enum logic [2:0] {
		TYPE_INT    = 3'd0,
		TYPE_UINT   = 3'd1,
		TYPE_LONG   = 3'd2,
		TYPE_ULONG  = 3'd3,
		TYPE_DOUBLE = 3'd4,
		TYPE_FLOAT  = 3'd5
	} cilc_type_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_signed_int;
		logic [CFG_W-1:0] max_unsigned_int;
		logic [CFG_W-1:0] max_signed_long;
	} cilc_cfg_t;

	typedef struct packed {
		logic [31:0] value;
		cilc_type_t  type_code;
		cilc_radix_t radix_code;
		logic        err_no_digits;
		logic        err_exponent_empty;
		logic        err_trailing_junk;
	} cilc_result_t;

endpackage

### rtl/cilc_scan.sv
// Literal scanner: per-character state update and result classification.
module cilc_scan
	import cilc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   char_code,
	input  logic         is_last,
	input  cilc_cfg_t    cfg,
	output cilc_result_t result
);

	typedef enum logic [11:0] {
		PH_START   = 12'b000000000001,
		PH_INT     = 12'b000000000010,
		PH_HEXPRE  = 12'b000000000100,
		PH_HEX     = 12'b000000001000,
		PH_SUFFIX  = 12'b000000010000,
		PH_IJUNK   = 12'b000000100000,
		PH_FRAC    = 12'b000001000000,
		PH_EXPMARK = 12'b000010000000,
		PH_EXPSIGN = 12'b000100000000,
		PH_EXPDIG  = 12'b001000000000,
		PH_FSUF    = 12'b010000000000,
		PH_FJUNK   = 12'b100000000000
	} cilc_phase_t;

	cilc_phase_t           phase_q, phase_work, phase_n;
	cilc_radix_t           radix_q, radix_n;
	logic [VALUE_BITS-1:0] acc_q, acc_n, acc_mac, acc_scaled;
	logic [1:0]            idx_q, idx_n;
	logic [1:0]            lcnt_q, lcnt_n;
	logic [1:0]            ucnt_q, ucnt_n;
	logic                  fflag_q, fflag_n;
	logic                  fsuf_q, fsuf_n;
	logic                  err_exp_q, err_exp_n;

	logic                  is_dig, is_hex, is_l, is_u, is_f, is_e, is_sign, is_dot;
	logic [3:0]            dig_val, hex_val, mac_digit;
	logic                  use_hex, hexpre_take;
	logic [CMP_W-1:0]      val_ext;
	logic                  le_int, le_uint, le_long;
	logic                  junk_end;

	assign is_dig  = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_hex  = is_dig || ((char_code >= 8'h61) && (char_code <= 8'h66))
		|| ((char_code >= 8'h41) && (char_code <= 8'h46));
	assign is_l    = (char_code == 8'h4C) || (char_code == 8'h6C);
	assign is_u    = (char_code == 8'h55) || (char_code == 8'h75);
	assign is_f    = (char_code == 8'h46) || (char_code == 8'h66);
	assign is_e    = (char_code == 8'h45) || (char_code == 8'h65);
	assign is_sign = (char_code == 8'h2B) || (char_code == 8'h2D);
	assign is_dot  = (char_code == 8'h2E);
	assign dig_val = char_code[3:0];
	assign hex_val = is_dig ? char_code[3:0] : (char_code[3:0] + 4'd9);

	assign hexpre_take = (phase_q == PH_INT) && (idx_q == 2'd1) && (radix_q == RADIX_OCT)
		&& ((char_code == 8'h78) || (char_code == 8'h58));

	assign phase_work = (phase_q == PH_START) ? PH_INT : phase_q;
	assign use_hex    = (phase_work == PH_HEXPRE) || (phase_work == PH_HEX);
	assign mac_digit  = use_hex ? hex_val : dig_val;

	always_comb begin
		if (use_hex) begin
			acc_scaled = acc_q << 4;
		end else if (radix_q == RADIX_OCT) begin
			acc_scaled = acc_q << 3;
		end else begin
			acc_scaled = (acc_q << 3) + (acc_q << 1);
		end
	end

	assign acc_mac = acc_scaled + VALUE_BITS'(mac_digit);

	always_comb begin
		phase_n     = phase_work;
		radix_n     = radix_q;
		acc_n       = acc_q;
		lcnt_n      = lcnt_q;
		ucnt_n      = ucnt_q;
		fflag_n     = fflag_q;
		fsuf_n      = fsuf_q;
		err_exp_n   = err_exp_q;
		idx_n       = (idx_q == 2'd3) ? idx_q : (idx_q + 2'd1);

		if (phase_q == PH_START) begin
			radix_n = (char_code == 8'h30) ? RADIX_OCT : RADIX_DEC;
		end

		if (hexpre_take) begin
			radix_n = RADIX_HEX;
			phase_n = PH_HEXPRE;
		end else begin
			case (phase_work)
				PH_INT: begin
					if (is_dig) begin
						acc_n = acc_mac;
					end else if (is_dot) begin
						fflag_n = 1'b1;
						phase_n = PH_FRAC;
					end else if (is_e) begin
						fflag_n = 1'b1;
						phase_n = PH_EXPMARK;
					end else if (is_l || is_u) begin
						phase_n = PH_SUFFIX;
					end else begin
						phase_n = PH_IJUNK;
					end
				end
				PH_HEXPRE, PH_HEX: begin
					if (is_hex) begin
						acc_n   = acc_mac;
						phase_n = PH_HEX;
					end else if (is_l || is_u) begin
						phase_n = PH_SUFFIX;
					end else begin
						phase_n = PH_IJUNK;
					end
				end
				PH_SUFFIX: begin
					if (!(is_l || is_u)) begin
						phase_n = PH_IJUNK;
					end
				end
				PH_FRAC: begin
					if (is_dig) begin
						phase_n = PH_FRAC;
					end else if (is_e) begin
						phase_n = PH_EXPMARK;
					end else if (is_f) begin
						fsuf_n  = 1'b1;
						phase_n = PH_FSUF;
					end else begin
						phase_n = PH_FJUNK;
					end
				end
				PH_EXPMARK, PH_EXPSIGN: begin
					if (is_sign && (phase_work == PH_EXPMARK)) begin
						phase_n = PH_EXPSIGN;
					end else if (is_dig) begin
						phase_n = PH_EXPDIG;
					end else begin
						err_exp_n = 1'b1;
						if (is_f) begin
							fsuf_n  = 1'b1;
							phase_n = PH_FSUF;
						end else begin
							phase_n = PH_FJUNK;
						end
					end
				end
				PH_EXPDIG: begin
					if (!is_dig) begin
						if (is_f) begin
							fsuf_n  = 1'b1;
							phase_n = PH_FSUF;
						end else begin
							phase_n = PH_FJUNK;
						end
					end
				end
				PH_FSUF: begin
					phase_n = PH_FJUNK;
				end
				default: begin
					phase_n = phase_work;
				end
			endcase

			if ((phase_work == PH_INT || use_hex || phase_work == PH_SUFFIX)
				&& !(phase_work == PH_INT && is_dig) && !(use_hex && is_hex)) begin
				if (is_l && lcnt_q != 2'd2) begin
					lcnt_n = lcnt_q + 2'd1;
				end
				if (is_u && ucnt_q != 2'd2) begin
					ucnt_n = ucnt_q + 2'd1;
				end
			end
		end
	end

	assign junk_end = (phase_n == PH_IJUNK) || (phase_n == PH_FJUNK);

	assign val_ext = CMP_W'(acc_n);
	assign le_int  = val_ext <= CMP_W'(cfg.max_signed_int);
	assign le_uint = val_ext <= CMP_W'(cfg.max_unsigned_int);
	assign le_long = val_ext <= CMP_W'(cfg.max_signed_long);

	always_comb begin
		result.radix_code         = radix_n;
		result.err_no_digits      = (phase_n == PH_HEXPRE);
		result.err_exponent_empty = err_exp_n || (phase_n == PH_EXPMARK)
			|| (phase_n == PH_EXPSIGN);
		if (fflag_n) begin
			result.value             = '0;
			result.type_code         = fsuf_n ? TYPE_FLOAT : TYPE_DOUBLE;
			result.err_trailing_junk = junk_end;
		end else begin
			result.value             = val_ext[31:0];
			result.err_trailing_junk = junk_end || (lcnt_n == 2'd2) || (ucnt_n == 2'd2);
			if (le_int && lcnt_n == 2'd0 && ucnt_n == 2'd0) begin
				result.type_code = TYPE_INT;
			end else if (le_uint && lcnt_n == 2'd0
				&& (radix_n != RADIX_DEC || ucnt_n != 2'd0)) begin
				result.type_code = TYPE_UINT;
			end else if (le_long && ucnt_n == 2'd0) begin
				result.type_code = TYPE_LONG;
			end else begin
				result.type_code = TYPE_ULONG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			radix_q     <= RADIX_DEC;
			acc_q       <= '0;
			idx_q       <= 2'd0;
			lcnt_q      <= 2'd0;
			ucnt_q      <= 2'd0;
			fflag_q     <= 1'b0;
			fsuf_q      <= 1'b0;
			err_exp_q   <= 1'b0;
		end else if (step) begin
			if (is_last) begin
				phase_q     <= PH_START;
				radix_q     <= RADIX_DEC;
				acc_q       <= '0;
				idx_q       <= 2'd0;
				lcnt_q      <= 2'd0;
				ucnt_q      <= 2'd0;
				fflag_q     <= 1'b0;
				fsuf_q      <= 1'b0;
				err_exp_q   <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				radix_q     <= radix_n;
				acc_q       <= acc_n;
				idx_q       <= idx_n;
				lcnt_q      <= lcnt_n;
				ucnt_q      <= ucnt_n;
				fflag_q     <= fflag_n;
				fsuf_q      <= fsuf_n;
				err_exp_q   <= err_exp_n;
			end
		end
	end

endmodule

### rtl/c_integer_literal_classifier_core.sv
// Top level of the C integer literal classifier: handshakes, config and result register.
// Takes one character of a C numeric literal per cycle unless stalled, with is_last marking
// the final character; a literal's result appears on out_valid once its last character has
// passed the input and result registers. Each character is registered, then one pass of
// scanner logic (base select, shift-add accumulate, suffix count, type compare against the
// three limit registers) feeds the result register. Input is stalled only while a finished
// result waits at the output and the held character is last. The user must write the limit
// registers via cfg_write/cfg_index/cfg_data only while no literal is in progress; unenforced.
`include "assert_macros.svh"

module c_integer_literal_classifier_core
	import cilc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_code,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          value_out,
	output logic [2:0]           type_code,
	output logic [1:0]           radix_code,
	output logic                 err_no_digits,
	output logic                 err_exponent_empty,
	output logic                 err_trailing_junk
);

	cilc_cfg_t    cfg_q;
	logic         valid_s1, last_s1;
	logic [7:0]   char_s1;
	logic         valid_s2;
	cilc_result_t res_s2;
	cilc_result_t scan_res;
	logic         advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_signed_int   <= RST_MAX_SIGNED_INT;
			cfg_q.max_unsigned_int <= RST_MAX_UNSIGNED_INT;
			cfg_q.max_signed_long  <= RST_MAX_SIGNED_LONG;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MAX_SIGNED_INT:   cfg_q.max_signed_int   <= cfg_data;
				CFG_MAX_UNSIGNED_INT: cfg_q.max_unsigned_int <= cfg_data;
				CFG_MAX_SIGNED_LONG:  cfg_q.max_signed_long  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance_s1 = valid_s1 && (!last_s1 || !valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	cilc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.char_code (char_s1),
		.is_last   (last_s1),
		.cfg       (cfg_q),
		.result    (scan_res)
	);

	// hold the result until transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			res_s2 <= scan_res;
		end
	end

	assign out_valid          = valid_s2;
	assign value_out          = res_s2.value;
	assign type_code          = res_s2.type_code;
	assign radix_code         = res_s2.radix_code;
	assign err_no_digits      = res_s2.err_no_digits;
	assign err_exponent_empty = res_s2.err_exponent_empty;
	assign err_trailing_junk  = res_s2.err_trailing_junk;

	`ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s1 && last_s1 && valid_s2 && out_stall)
	`ASSERT_NXT(a_last_lands, clk, arst_n, advance_s1 && last_s1, valid_s2)
	`ASSERT_IMP(a_float_zero, clk, arst_n, valid_s2 && (res_s2.type_code == TYPE_DOUBLE || res_s2.type_code == TYPE_FLOAT), res_s2.value == 32'd0)
	`ASSERT_IMP(a_nodig_hex, clk, arst_n, valid_s2 && res_s2.err_no_digits, res_s2.radix_code == RADIX_HEX && res_s2.type_code == TYPE_INT)
	`ASSERT_IMP(a_exp_float, clk, arst_n, valid_s2 && res_s2.err_exponent_empty, res_s2.type_code == TYPE_DOUBLE || res_s2.type_code == TYPE_FLOAT)

endmodule
